/* hw/rtl/q4td_pkg.sv */
// Shared constants, codes and types for the 4-bit tile dequantizer.
package q4td_pkg;

   localparam int ROWS_PER_BLOCK  = 16;
   localparam int K_PER_BLOCK     = 32;
   localparam int DEF_ROW_BLOCKS  = 2;
   localparam int DEF_K_BLOCKS    = 8;
   localparam int TABLE_DEPTH     = 256;
   localparam int TABLE_IDX_W     = $clog2(TABLE_DEPTH);
   localparam int BANK_DEPTH      = TABLE_DEPTH / 2;
   localparam int BF16_W          = 16;
   localparam int WIDX_W          = 13;
   localparam int ROW_PAIRS       = ROWS_PER_BLOCK / 2;
   localparam int RP_W            = $clog2(ROW_PAIRS);
   localparam int KK_W            = $clog2(K_PER_BLOCK);

   localparam logic [BF16_W-1:0] BF16_QNAN_DEFAULT = 16'hFFC0;
   localparam logic [BF16_W-1:0] BF16_QUIET_BIT    = 16'h0040;

   typedef enum logic [1:0] {
      FUNC_SCALE  = 2'd0,
      FUNC_MIN    = 2'd1,
      FUNC_WEIGHT = 2'd2
   } func_type;

   typedef struct packed {
      logic mul;
      logic add;
      logic rnd;
   } adv_type;

endpackage

/* hw/rtl/q4td_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module q4td_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hw/rtl/q4td_lane.sv */
// One dequant lane: code*d exact product, fp32 add of m with RNE, bf16 RNE.
module q4td_lane
   import q4td_pkg::*;
(
   input  logic              clock,
   input  adv_type           adv,
   input  logic [3:0]        code,
   input  logic [BF16_W-1:0] d,
   input  logic [BF16_W-1:0] m,
   output logic [BF16_W-1:0] result
);

   // multiply stage
   logic [7:0]        ed, em;
   logic              d_zero, d_inf, d_nan, m_zero, m_inf, m_nan, p_zero, p_inf, code_zero;
   logic [11:0]       prod, psig, msig;
   logic [2:0]        sh;
   logic [8:0]        pexp;
   logic              spec_in;
   logic [BF16_W-1:0] sval_in;

   logic              spec_a_ff, ps_a_ff, ms_a_ff;
   logic [BF16_W-1:0] sval_a_ff;
   logic [7:0]        pe_a_ff, me_a_ff;
   logic [11:0]       psig_a_ff, msig_a_ff;

   always_comb begin
      ed        = d[14:7];
      em        = m[14:7];
      code_zero = (code == 4'd0);
      d_zero    = (ed == 8'd0);
      d_inf     = (ed == 8'hFF) && (d[6:0] == 7'd0);
      d_nan     = (ed == 8'hFF) && (d[6:0] != 7'd0);
      m_zero    = (em == 8'd0);
      m_inf     = (em == 8'hFF) && (m[6:0] == 7'd0);
      m_nan     = (em == 8'hFF) && (m[6:0] != 7'd0);
      prod      = 12'({1'b1, d[6:0]}) * 12'(code);
      priority if (prod[11]) sh = 3'd4;
      else if (prod[10])     sh = 3'd3;
      else if (prod[9])      sh = 3'd2;
      else if (prod[8])      sh = 3'd1;
      else                   sh = 3'd0;
      psig   = prod << (3'd4 - sh);
      pexp   = 9'(ed) + 9'(sh);
      p_zero = d_zero || code_zero;
      p_inf  = !code_zero && (d_inf || (!d_zero && !d_nan && (pexp >= 9'd255)));
      msig   = {1'b1, m[6:0], 4'b0};

      spec_in = 1'b1;
      priority if (d_nan)                          sval_in = d | BF16_QUIET_BIT;
      else if (d_inf && code_zero)                 sval_in = BF16_QNAN_DEFAULT;
      else if (m_nan)                              sval_in = m | BF16_QUIET_BIT;
      else if (p_inf && m_inf && (d[15] != m[15])) sval_in = BF16_QNAN_DEFAULT;
      else if (p_inf)                              sval_in = {d[15], 8'hFF, 7'd0};
      else if (m_inf)                              sval_in = {m[15], 8'hFF, 7'd0};
      else if (p_zero && m_zero)                   sval_in = {d[15] & m[15], 15'd0};
      else if (p_zero)                             sval_in = m;
      else begin
         spec_in = 1'b0;
         sval_in = m;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.mul) begin
         spec_a_ff <= spec_in;
         sval_a_ff <= sval_in;
         ps_a_ff   <= d[15];
         ms_a_ff   <= m[15];
         pe_a_ff   <= pexp[7:0];
         psig_a_ff <= psig;
         me_a_ff   <= m_zero ? 8'd0 : em;
         msig_a_ff <= m_zero ? 12'd0 : msig;
      end
   end

   // align and add stage
   logic              a_big, sa, sb;
   logic [7:0]        ea, eb, diff;
   logic [11:0]       siga, sigb;
   logic [27:0]       wa, wb, bsh, smask, sum_in;
   logic              sticky;

   logic              spec_b_ff, s_b_ff;
   logic [BF16_W-1:0] sval_b_ff;
   logic [7:0]        e_b_ff;
   logic [27:0]       sum_b_ff;

   always_comb begin
      a_big = ({pe_a_ff, psig_a_ff} >= {me_a_ff, msig_a_ff});
      ea    = a_big ? pe_a_ff : me_a_ff;
      eb    = a_big ? me_a_ff : pe_a_ff;
      siga  = a_big ? psig_a_ff : msig_a_ff;
      sigb  = a_big ? msig_a_ff : psig_a_ff;
      sa    = a_big ? ps_a_ff : ms_a_ff;
      sb    = a_big ? ms_a_ff : ps_a_ff;
      diff  = ea - eb;
      wa    = {1'b0, siga, 15'd0};
      wb    = {1'b0, sigb, 15'd0};
      if (diff >= 8'd27) begin
         bsh    = 28'd0;
         sticky = |sigb;
         smask  = 28'd0;
      end else begin
         smask  = (28'd1 << diff[4:0]) - 28'd1;
         bsh    = wb >> diff[4:0];
         sticky = |(wb & smask);
      end
      bsh[0] = bsh[0] | sticky;
      sum_in = (sa ^ sb) ? (wa - bsh) : (wa + bsh);
   end

   always_ff @(posedge clock) begin
      if (adv.add) begin
         spec_b_ff <= spec_a_ff;
         sval_b_ff <= sval_a_ff;
         s_b_ff    <= sa;
         e_b_ff    <= ea;
         sum_b_ff  <= sum_in;
      end
   end

   // normalize and round stage
   logic [26:0] norm;
   logic [4:0]  lz;
   logic [9:0]  en;
   logic [24:0] mr;
   logic        up;
   logic [31:0] u, ur;
   logic [BF16_W-1:0] res_in;

   always_comb begin
      lz = 5'd0;
      for (int i = 0; i < 27; i++) begin
         if (sum_b_ff[i]) lz = 5'(26 - i);
      end
      if (sum_b_ff[27]) begin
         norm = {sum_b_ff[27:2], sum_b_ff[1] | sum_b_ff[0]};
         en   = 10'(e_b_ff) + 10'd1;
      end else begin
         norm = sum_b_ff[26:0] << lz;
         en   = 10'(e_b_ff) - 10'(lz);
      end
      up = norm[2] & (norm[1] | norm[0] | norm[3]);
      mr = {1'b0, norm[26:3]} + 25'(up);
      if (mr[24]) en = en + 10'd1;
      if (sum_b_ff == 28'd0) begin
         u = 32'd0;
      end else if (!en[9] && (en >= 10'd255)) begin
         u = {s_b_ff, 8'hFF, 23'd0};
      end else if (en[9] || (en == 10'd0)) begin
         u = {s_b_ff, 31'd0};
      end else begin
         u = {s_b_ff, en[7:0], mr[22:0]};
      end
      ur     = u + 32'h0000_7FFF + 32'(u[16]);
      res_in = spec_b_ff ? sval_b_ff : ur[31:16];
   end

   always_ff @(posedge clock) begin
      if (adv.rnd) begin
         result <= res_in;
      end
   end

endmodule

/* hw/rtl/q4_tile_dequantizer_unit.sv */
// Top level of the 4-bit tile dequantizer: tables, tile walker and pipeline.
// An accepted weight beat is registered by table read, multiply, align/add and
//   normalize/round into the output register. Throughput: one beat per cycle
//   while rsp_tready takes results; table writes and weight beats share the port.
// Stages hold only when the stage ahead is full, so bubbles are squeezed out.
// Reset clears the tile position and the stage valids; tables are not cleared.
module q4_tile_dequantizer_unit
   import q4td_pkg::*;
#(
   parameter int ROW_BLOCKS = DEF_ROW_BLOCKS,
   parameter int K_BLOCKS   = DEF_K_BLOCKS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // table_index[7:0], value[23:8]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // weight_index[12:0], weight_even[28:13],
                                   // weight_odd[44:29], zero[47:45]
   output logic        rsp_tlast   // tile_last
);

   localparam int TILE_BYTES = ROW_BLOCKS * K_BLOCKS * K_PER_BLOCK * ROWS_PER_BLOCK / 2;
   localparam int POS_W      = $clog2(TILE_BYTES);
   localparam int KB_W       = (K_BLOCKS > 1) ? $clog2(K_BLOCKS) : 1;
   localparam int RB_W       = (ROW_BLOCKS > 1) ? $clog2(ROW_BLOCKS) : 1;
   localparam int IDX_STRIDE = ROW_BLOCKS * ROWS_PER_BLOCK;

   logic [TABLE_IDX_W-1:0] tix;
   logic [BF16_W-1:0]      value;
   logic                   accept, is_weight, wr_scale, wr_min;

   assign tix       = req_tdata[7:0];
   assign value     = req_tdata[23:8];
   assign accept    = req_tvalid && req_tready;
   assign is_weight = (req_tuser == FUNC_WEIGHT);
   assign wr_scale  = accept && (req_tuser == FUNC_SCALE);
   assign wr_min    = accept && (req_tuser == FUNC_MIN);

   // tile walker
   logic [RP_W-1:0]  rp_ff, rp_in;
   logic [KK_W-1:0]  kk_ff, kk_in;
   logic [KB_W-1:0]  kb_ff, kb_in;
   logic [RB_W-1:0]  rb_ff, rb_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             step, tile_end;
   logic [15:0]      idx_full;
   logic [TABLE_IDX_W-1:0] idx;

   assign step     = accept && is_weight;
   assign tile_end = (pos_ff == POS_W'(TILE_BYTES - 1));
   assign idx_full = 16'(kb_ff) * 16'(IDX_STRIDE) + 16'(rb_ff) * 16'(ROWS_PER_BLOCK)
                   + 16'({rp_ff, 1'b0});
   assign idx      = idx_full[TABLE_IDX_W-1:0];

   always_comb begin
      rp_in  = rp_ff;
      kk_in  = kk_ff;
      kb_in  = kb_ff;
      rb_in  = rb_ff;
      pos_in = pos_ff;
      if (step) begin
         pos_in = tile_end ? '0 : pos_ff + POS_W'(1);
         rp_in  = rp_ff + RP_W'(1);
         if (rp_ff == RP_W'(ROW_PAIRS - 1)) begin
            kk_in = kk_ff + KK_W'(1);
            if (kk_ff == KK_W'(K_PER_BLOCK - 1)) begin
               kb_in = (kb_ff == KB_W'(K_BLOCKS - 1)) ? '0 : kb_ff + KB_W'(1);
               if (kb_ff == KB_W'(K_BLOCKS - 1)) begin
                  rb_in = (rb_ff == RB_W'(ROW_BLOCKS - 1)) ? '0 : rb_ff + RB_W'(1);
               end
            end
         end
      end
   end

   // tables: even and odd entries in separate banks so a pair reads at once
   logic [BF16_W-1:0] sc_even, sc_odd, mn_even, mn_odd;

   q4td_ram #(.WIDTH(BF16_W), .DEPTH(BANK_DEPTH)) u_scale_even (
      .clock(clock), .wr_en(wr_scale && !tix[0]), .wr_addr(tix[TABLE_IDX_W-1:1]),
      .wr_data(value), .rd_en(step), .rd_addr(idx[TABLE_IDX_W-1:1]), .rd_data(sc_even));
   q4td_ram #(.WIDTH(BF16_W), .DEPTH(BANK_DEPTH)) u_scale_odd (
      .clock(clock), .wr_en(wr_scale && tix[0]), .wr_addr(tix[TABLE_IDX_W-1:1]),
      .wr_data(value), .rd_en(step), .rd_addr(idx[TABLE_IDX_W-1:1]), .rd_data(sc_odd));
   q4td_ram #(.WIDTH(BF16_W), .DEPTH(BANK_DEPTH)) u_min_even (
      .clock(clock), .wr_en(wr_min && !tix[0]), .wr_addr(tix[TABLE_IDX_W-1:1]),
      .wr_data(value), .rd_en(step), .rd_addr(idx[TABLE_IDX_W-1:1]), .rd_data(mn_even));
   q4td_ram #(.WIDTH(BF16_W), .DEPTH(BANK_DEPTH)) u_min_odd (
      .clock(clock), .wr_en(wr_min && tix[0]), .wr_addr(tix[TABLE_IDX_W-1:1]),
      .wr_data(value), .rd_en(step), .rd_addr(idx[TABLE_IDX_W-1:1]), .rd_data(mn_odd));

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic free1, free2, free3, free4;
   adv_type adv;

   assign free4   = !v4_ff || rsp_tready;
   assign free3   = !v3_ff || free4;
   assign free2   = !v2_ff || free3;
   assign free1   = !v1_ff || free2;
   assign adv.mul = v1_ff && free2;
   assign adv.add = v2_ff && free3;
   assign adv.rnd = v3_ff && free4;
   assign v1_in   = step || (v1_ff && !free2);
   assign v2_in   = adv.mul || (v2_ff && !free3);
   assign v3_in   = adv.add || (v3_ff && !free4);
   assign v4_in   = adv.rnd || (v4_ff && !rsp_tready);
   assign req_tready = free1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         rp_ff  <= '0;
         kk_ff  <= '0;
         kb_ff  <= '0;
         rb_ff  <= '0;
         pos_ff <= '0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         v4_ff  <= v4_in;
         rp_ff  <= rp_in;
         kk_ff  <= kk_in;
         kb_ff  <= kb_in;
         rb_ff  <= rb_in;
         pos_ff <= pos_in;
      end
   end

   // sideband through the stages
   logic [7:0]        byte1_ff;
   logic [WIDX_W-1:0] widx1_ff, widx2_ff, widx3_ff, widx4_ff;
   logic              last1_ff, last2_ff, last3_ff, last4_ff;

   always_ff @(posedge clock) begin
      if (step) begin
         byte1_ff <= value[7:0];
         widx1_ff <= WIDX_W'({pos_ff, 1'b0});
         last1_ff <= tile_end;
      end
      if (adv.mul) begin
         widx2_ff <= widx1_ff;
         last2_ff <= last1_ff;
      end
      if (adv.add) begin
         widx3_ff <= widx2_ff;
         last3_ff <= last2_ff;
      end
      if (adv.rnd) begin
         widx4_ff <= widx3_ff;
         last4_ff <= last3_ff;
      end
   end

   logic [BF16_W-1:0] w_even, w_odd;

   q4td_lane u_lane_even (
      .clock(clock), .adv(adv), .code(byte1_ff[3:0]), .d(sc_even), .m(mn_even),
      .result(w_even));
   q4td_lane u_lane_odd (
      .clock(clock), .adv(adv), .code(byte1_ff[7:4]), .d(sc_odd), .m(mn_odd),
      .result(w_odd));

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {3'b000, w_odd, w_even, widx4_ff};
   assign rsp_tlast  = last4_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v1_ff)
      else $error("input stalled with table read stage empty");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[WIDX_W-1:0] == WIDX_W'(2 * (TILE_BYTES - 1))))
      else $error("tile end flagged at wrong weight index");

   a_tile_wrap: assert property (@(posedge clock) disable iff (reset)
      (step && tile_end) |=> (pos_ff == '0 && rp_ff == '0 && kk_ff == '0
                              && kb_ff == '0 && rb_ff == '0))
      else $error("tile walker did not wrap at tile end");

   a_walker_sync: assert property (@(posedge clock) disable iff (reset)
      (rp_ff == pos_ff[RP_W-1:0]) && (kk_ff == pos_ff[RP_W+KK_W-1:RP_W]))
      else $error("row pair or k counter out of step with byte position");

endmodule
